// ===== design/round_robin_task_scheduler_macros.svh =====
// ----------------------------------------------------------------------------
// Round-robin task scheduler assertion macros
// Shared overlapping-implication and next-cycle assertion forms.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

`define RRTS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`define RRTS_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// Round-robin task scheduler package
// Transaction payload types, request modes, slot states and register map.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam logic [2:0] MODE_MARK   = 3'd0;
    localparam logic [2:0] MODE_SCHED  = 3'd1;
    localparam logic [2:0] MODE_WRITE  = 3'd2;
    localparam logic [2:0] MODE_SETCUR = 3'd3;
    localparam logic [2:0] MODE_TICK   = 3'd4;

    localparam logic [1:0] ST_OTHER   = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;
    localparam logic [1:0] ST_DEAD    = 2'd3;

    localparam int         CFG_ADDR_W       = 3;
    localparam logic [0:0] CFG_IDX_SCHED_EN = 1'b0;

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] slot_index;
        logic [1:0] new_state;
    } in_item_t;

    typedef struct packed {
        logic        switched;
        logic [3:0]  next_slot;
        logic [3:0]  prev_slot;
        logic        reap_prev;
        logic        none_runnable;
        logic        current_valid;
        logic [31:0] tick_count;
    } out_item_t;

endpackage

// ===== design/rrts_ram.sv =====
// ----------------------------------------------------------------------------
// Round-robin task scheduler RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module rrts_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/round_robin_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// Round-robin task scheduler
// Results are loaded in S_DONE: after S_MARK or S_APPLY, straight from S_IDLE for a
// skipped schedule search, or after an S_SCAN slot walk; new transactions wait for S_IDLE.
// Synchronous reset clears the slot table, current task, pointer, ticks and enable.
// ----------------------------------------------------------------------------
`include "round_robin_task_scheduler_macros.svh"

module round_robin_task_scheduler #(
    parameter int TASK_SLOTS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rrts_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  rrts_pkg::in_item_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output rrts_pkg::out_item_t                   m_data
);

    import rrts_pkg::*;

    localparam int SLOT_W = $clog2(TASK_SLOTS);
    localparam int WIDE_W = (SLOT_W > 4) ? SLOT_W : 4;
    localparam int CMP_W  = WIDE_W + 1;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MARK   = 7'b0000010,
        S_APPLY  = 7'b0000100,
        S_SCAN   = 7'b0001000,
        S_WRPREV = 7'b0010000,
        S_WRNEXT = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    in_item_t              item_reg, item_next;
    logic [SLOT_W-1:0]     cur_reg, cur_next;
    logic                  cur_set_reg, cur_set_next;
    logic [SLOT_W-1:0]     ptr_reg, ptr_next;
    logic [31:0]           ticks_reg, ticks_next;
    logic                  en_reg, en_next;
    logic [SLOT_W-1:0]     prev_reg, prev_next;
    logic                  sw_reg, sw_next;
    logic                  reap_reg, reap_next;
    logic                  none_reg, none_next;
    logic [SLOT_W-1:0]     scan_addr_reg, scan_addr_next;
    logic [SLOT_W-1:0]     chk_addr_reg, chk_addr_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic [SLOT_W-1:0]     cnt_reg, cnt_next;
    logic [1:0]            cur_st_reg, cur_st_next;
    logic [SLOT_W-1:0]     next_reg, next_next;
    logic [TASK_SLOTS-1:0] valid_reg, valid_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_data_reg, m_data_next;

    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_waddr;
    logic [1:0]            ram_wdata;
    logic [SLOT_W-1:0]     ram_raddr;
    logic [1:0]            ram_rdata;
    logic [1:0]            st_rd;

    logic [WIDE_W-1:0]     s_idx_wide;
    logic [WIDE_W-1:0]     item_idx_wide;
    logic [SLOT_W-1:0]     item_slot;
    logic                  item_in_range;
    logic [WIDE_W-1:0]     cur_wide;
    logic [WIDE_W-1:0]     prev_wide;
    logic                  cfg_wr;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] a);
        return (a == SLOT_W'(TASK_SLOTS - 1)) ? '0 : SLOT_W'(a + 1'b1);
    endfunction

    rrts_ram #(
        .WIDTH(2),
        .DEPTH(TASK_SLOTS)
    ) u_state_ram (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign st_rd         = rd_vld_reg ? ram_rdata : ST_OTHER;
    assign s_idx_wide    = WIDE_W'(s_data.slot_index);
    assign item_idx_wide = WIDE_W'(item_reg.slot_index);
    assign item_slot     = item_idx_wide[SLOT_W-1:0];
    assign item_in_range = CMP_W'(item_reg.slot_index) < CMP_W'(TASK_SLOTS);
    assign cur_wide      = WIDE_W'(cur_reg);
    assign prev_wide     = WIDE_W'(prev_reg);

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = (paddr[CFG_ADDR_W-1:2] == CFG_IDX_SCHED_EN) ? {31'd0, en_reg} : 32'd0;
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        cur_next       = cur_reg;
        cur_set_next   = cur_set_reg;
        ptr_next       = ptr_reg;
        ticks_next     = ticks_reg;
        en_next        = en_reg;
        prev_next      = prev_reg;
        sw_next        = sw_reg;
        reap_next      = reap_reg;
        none_next      = none_reg;
        scan_addr_next = scan_addr_reg;
        chk_addr_next  = chk_addr_reg;
        chk_vld_next   = chk_vld_reg;
        cnt_next       = cnt_reg;
        cur_st_next    = cur_st_reg;
        next_next      = next_reg;
        valid_next     = valid_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_reg;
        ram_wdata      = ST_OTHER;
        ram_raddr      = cur_reg;

        if (cfg_wr && (paddr[CFG_ADDR_W-1:2] == CFG_IDX_SCHED_EN)) begin
            en_next = pwdata[0];
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                    prev_next = cur_reg;
                    sw_next   = 1'b0;
                    reap_next = 1'b0;
                    none_next = 1'b0;
                    unique case (s_data.mode)
                        MODE_MARK: begin
                            ram_raddr  = s_idx_wide[SLOT_W-1:0];
                            state_next = S_MARK;
                        end
                        MODE_SCHED: begin
                            if (en_reg && cur_set_reg) begin
                                ram_raddr      = cur_reg;
                                scan_addr_next = slot_inc(ptr_reg);
                                chk_vld_next   = 1'b0;
                                cnt_next       = '0;
                                state_next     = S_SCAN;
                            end else begin
                                state_next = S_DONE;
                            end
                        end
                        default: begin
                            state_next = S_APPLY;
                        end
                    endcase
                end
            end
            S_MARK: begin
                if (item_in_range && (st_rd != ST_RUNNING)) begin
                    ram_we    = 1'b1;
                    ram_waddr = item_slot;
                    ram_wdata = ST_READY;
                end
                state_next = S_DONE;
            end
            S_APPLY: begin
                unique case (item_reg.mode)
                    MODE_WRITE: begin
                        if (item_in_range) begin
                            ram_we    = 1'b1;
                            ram_waddr = item_slot;
                            ram_wdata = item_reg.new_state;
                        end
                    end
                    MODE_SETCUR: begin
                        if (item_in_range) begin
                            cur_next     = item_slot;
                            cur_set_next = 1'b1;
                        end
                    end
                    MODE_TICK: begin
                        ticks_next = ticks_reg + 32'd1;
                    end
                    default: begin
                    end
                endcase
                state_next = S_DONE;
            end
            S_SCAN: begin
                ram_raddr      = scan_addr_reg;
                scan_addr_next = slot_inc(scan_addr_reg);
                chk_addr_next  = scan_addr_reg;
                chk_vld_next   = 1'b1;
                if (!chk_vld_reg) begin
                    cur_st_next = st_rd;
                end else if (st_rd == ST_READY) begin
                    ptr_next   = chk_addr_reg;
                    next_next  = chk_addr_reg;
                    state_next = (chk_addr_reg != cur_reg) ? S_WRPREV : S_DONE;
                end else if (cnt_reg == SLOT_W'(TASK_SLOTS - 1)) begin
                    if (!((cur_st_reg == ST_RUNNING) || (cur_st_reg == ST_READY))) begin
                        none_next = 1'b1;
                    end
                    state_next = S_DONE;
                end else begin
                    cnt_next = SLOT_W'(cnt_reg + 1'b1);
                end
            end
            S_WRPREV: begin
                if (cur_st_reg == ST_RUNNING) begin
                    ram_we    = 1'b1;
                    ram_waddr = cur_reg;
                    ram_wdata = ST_READY;
                end
                sw_next    = 1'b1;
                reap_next  = (cur_st_reg == ST_DEAD);
                state_next = S_WRNEXT;
            end
            S_WRNEXT: begin
                ram_we     = 1'b1;
                ram_waddr  = next_reg;
                ram_wdata  = ST_RUNNING;
                cur_next   = next_reg;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.switched      = sw_reg;
                    m_data_next.next_slot     = cur_wide[3:0];
                    m_data_next.prev_slot     = prev_wide[3:0];
                    m_data_next.reap_prev     = reap_reg;
                    m_data_next.none_runnable = none_reg;
                    m_data_next.current_valid = cur_set_reg;
                    m_data_next.tick_count    = ticks_reg;
                    state_next                = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (ram_we) begin
            valid_next[ram_waddr] = 1'b1;
        end
        rd_vld_next = valid_reg[ram_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cur_reg     <= '0;
            cur_set_reg <= 1'b0;
            ptr_reg     <= '0;
            ticks_reg   <= '0;
            en_reg      <= 1'b0;
            valid_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            chk_vld_reg <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            cur_set_reg <= cur_set_next;
            ptr_reg     <= ptr_next;
            ticks_reg   <= ticks_next;
            en_reg      <= en_next;
            valid_reg   <= valid_next;
            rd_vld_reg  <= rd_vld_next;
            chk_vld_reg <= chk_vld_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        prev_reg      <= prev_next;
        sw_reg        <= sw_next;
        reap_reg      <= reap_next;
        none_reg      <= none_next;
        scan_addr_reg <= scan_addr_next;
        chk_addr_reg  <= chk_addr_next;
        cur_st_reg    <= cur_st_next;
        next_reg      <= next_next;
        m_data_reg    <= m_data_next;
    end

    `RRTS_ASSERT_IMP(a_reap_needs_switch, aclk, aresetn, m_valid && m_data.reap_prev, m_data.switched, "reap flagged without a task switch")
    `RRTS_ASSERT_IMP(a_none_no_switch, aclk, aresetn, m_valid && m_data.none_runnable, !m_data.switched, "switch reported with no runnable task")
    `RRTS_ASSERT_IMP(a_switch_changes_slot, aclk, aresetn, m_valid && m_data.switched, m_data.next_slot != m_data.prev_slot, "switch kept the same slot")
    `RRTS_ASSERT_NXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready, "new transaction accepted while one is in progress")

endmodule

// ===== bench/round_robin_task_scheduler_checker.sv =====
// ----------------------------------------------------------------------------
// Round-robin task scheduler checker
// Watches the configuration port and both transaction channels, keeps its
// own copy of the slot table, current task, pointer and tick counter, and
// compares every result transaction field by field with the oldest
// predicted one. Mismatches, unexpected results and the number of results
// still owed are handed to the test top.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_checker
    import rrts_pkg::*;
#(
    parameter int TASK_SLOTS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    input  logic                  pready,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_data,
    output int                    fail_count,
    output int                    outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    logic [1:0]  slot_state [TASK_SLOTS];
    int unsigned cur_slot;
    bit          cur_set;
    int unsigned rr_ptr;
    logic [31:0] tick_ctr;
    bit          sched_en;

    out_item_t   sched_reports_q [$];

    function automatic out_item_t apply_request(input in_item_t req);
        out_item_t   rpt;
        int unsigned cur_before;
        int unsigned start;
        int unsigned s;
        int unsigned nxt;
        int unsigned prev;
        int unsigned i;
        bit          found;
        bit          sw;
        bit          reap;
        bit          none;
        bit          in_range;

        cur_before = cur_slot;
        sw         = 1'b0;
        reap       = 1'b0;
        none       = 1'b0;
        in_range   = (req.slot_index < TASK_SLOTS);

        case (req.mode)
            MODE_MARK: begin
                if (in_range && slot_state[req.slot_index] != ST_RUNNING) begin
                    slot_state[req.slot_index] = ST_READY;
                end
            end
            MODE_SCHED: begin
                if (sched_en && cur_set) begin
                    start = (rr_ptr + 1) % TASK_SLOTS;
                    found = 1'b0;
                    nxt   = 0;
                    for (i = 0; i < TASK_SLOTS && !found; i++) begin
                        s = (start + i) % TASK_SLOTS;
                        if (slot_state[s] == ST_READY) begin
                            rr_ptr = s;
                            nxt    = s;
                            found  = 1'b1;
                        end
                    end
                    if (!found) begin
                        if (slot_state[cur_slot] == ST_RUNNING ||
                            slot_state[cur_slot] == ST_READY) begin
                            nxt   = cur_slot;
                            found = 1'b1;
                        end else begin
                            none = 1'b1;
                        end
                    end
                    if (found && nxt != cur_slot) begin
                        prev = cur_slot;
                        if (slot_state[prev] == ST_RUNNING) begin
                            slot_state[prev] = ST_READY;
                        end
                        slot_state[nxt] = ST_RUNNING;
                        cur_slot        = nxt;
                        sw              = 1'b1;
                        reap            = (slot_state[prev] == ST_DEAD);
                    end
                end
            end
            MODE_WRITE: begin
                if (in_range) begin
                    slot_state[req.slot_index] = req.new_state;
                end
            end
            MODE_SETCUR: begin
                if (in_range) begin
                    cur_slot = req.slot_index;
                    cur_set  = 1'b1;
                end
            end
            MODE_TICK: begin
                tick_ctr = tick_ctr + 32'd1;
            end
            default: begin
            end
        endcase

        rpt.switched      = sw;
        rpt.next_slot     = 4'(cur_slot);
        rpt.prev_slot     = 4'(cur_before);
        rpt.reap_prev     = reap;
        rpt.none_runnable = none;
        rpt.current_valid = cur_set;
        rpt.tick_count    = tick_ctr;
        return rpt;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] exp_val,
                                 input logic [31:0] act_val);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h",
                     $realtime, what, exp_val, act_val);
        end
    endtask

    always @(posedge aclk) begin
        out_item_t exp_item;

        if (!aresetn) begin
            foreach (slot_state[k]) begin
                slot_state[k] = ST_OTHER;
            end
            cur_slot   = 0;
            cur_set    = 1'b0;
            rr_ptr     = 0;
            tick_ctr   = '0;
            sched_en   = 1'b0;
            sched_reports_q.delete();
            fail_count  = 0;
            outstanding = 0;
        end else begin
            if (psel && penable && pwrite && pready &&
                (paddr >> 2) == CFG_IDX_SCHED_EN) begin
                sched_en = pwdata[0];
            end

            if (m_valid && m_ready) begin
                if (sched_reports_q.size() == 0) begin
                    flag_mismatch("unexpected result transaction", '0, m_data.next_slot);
                end else begin
                    exp_item = sched_reports_q.pop_front();
                    if (m_data.switched !== exp_item.switched)
                        flag_mismatch("switched", exp_item.switched, m_data.switched);
                    if (m_data.next_slot !== exp_item.next_slot)
                        flag_mismatch("next_slot", exp_item.next_slot, m_data.next_slot);
                    if (m_data.prev_slot !== exp_item.prev_slot)
                        flag_mismatch("prev_slot", exp_item.prev_slot, m_data.prev_slot);
                    if (m_data.reap_prev !== exp_item.reap_prev)
                        flag_mismatch("reap_prev", exp_item.reap_prev, m_data.reap_prev);
                    if (m_data.none_runnable !== exp_item.none_runnable)
                        flag_mismatch("none_runnable", exp_item.none_runnable,
                                      m_data.none_runnable);
                    if (m_data.current_valid !== exp_item.current_valid)
                        flag_mismatch("current_valid", exp_item.current_valid,
                                      m_data.current_valid);
                    if (m_data.tick_count !== exp_item.tick_count)
                        flag_mismatch("tick_count", exp_item.tick_count, m_data.tick_count);
                end
            end

            if (s_valid && s_ready) begin
                sched_reports_q.push_back(apply_request(s_data));
            end

            outstanding = sched_reports_q.size();
        end
    end

endmodule

// ===== bench/round_robin_task_scheduler_test.sv =====
// ----------------------------------------------------------------------------
// Round-robin task scheduler test
// Drives a directed sequence covering every request mode and the scheduling
// corner cases, then random request phases under several enable settings
// with random idling on both channels and one long result back-pressure
// stretch. Checking is done by the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_test;

    import rrts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS            = 16;
    localparam int CLK_HALF         = 6;
    localparam int RANDOM_ITEMS     = 1600;
    localparam int PHASES           = 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES      = 2 * SLOTS;
    localparam int TIMEOUT_CYCLES   = 400_000;

    localparam logic [CFG_ADDR_W-1:0] SCHED_EN_ADDR  = CFG_ADDR_W'(4 * CFG_IDX_SCHED_EN);
    localparam logic [2:0]            MODE_UNUSED_LO = 3'd5;
    localparam logic [2:0]            MODE_UNUSED_HI = 3'd7;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;

    int fail_count;
    int outstanding;
    bit gaps_on;
    bit long_hold_req;

    round_robin_task_scheduler #(
        .TASK_SLOTS (SLOTS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    round_robin_task_scheduler_checker #(
        .TASK_SLOTS (SLOTS)
    ) checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always begin
        aclk = 1'b0;
        #CLK_HALF;
        aclk = 1'b1;
        #CLK_HALF;
    end

    function automatic in_item_t req(input logic [2:0] mode, input int slot,
                                     input logic [1:0] state);
        in_item_t r;

        r.mode       = mode;
        r.slot_index = 4'(slot);
        r.new_state  = state;
        return r;
    endfunction

    function automatic in_item_t random_request();
        in_item_t r;
        int       pick;

        pick         = $urandom_range(0, 99);
        r.slot_index = 4'($urandom_range(0, SLOTS - 1));
        r.new_state  = 2'($urandom_range(0, 3));
        if (pick < 25) begin
            r.mode = MODE_MARK;
        end else if (pick < 55) begin
            r.mode = MODE_SCHED;
        end else if (pick < 75) begin
            r.mode = MODE_WRITE;
        end else if (pick < 84) begin
            r.mode = MODE_SETCUR;
        end else if (pick < 96) begin
            r.mode = MODE_TICK;
        end else begin
            r.mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
        end
        return r;
    endfunction

    task automatic send_request(input in_item_t item);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_sched_enable(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SCHED_EN_ADDR;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (outstanding != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge aclk);
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 15)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        #(2 * CLK_HALF * TIMEOUT_CYCLES);
        $display("** round_robin_task_scheduler: FAILED **");
        $finish;
    end

    initial begin
        logic [31:0] cfg_word;
        bit          en;

        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_valid       = 1'b0;
        s_data        = '0;
        gaps_on       = 1'b1;
        long_hold_req = 1'b0;

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Scheduling disabled: requests must leave the task table alone.
        send_request(req(MODE_SCHED, 0, ST_OTHER));
        send_request(req(MODE_SETCUR, 0, ST_OTHER));
        send_request(req(MODE_SCHED, 0, ST_OTHER));
        send_request(req(MODE_UNUSED_LO, 15, ST_DEAD));
        send_request(req(MODE_UNUSED_HI, 0, ST_READY));
        send_request(req(MODE_TICK, 15, ST_RUNNING));
        s_valid <= 1'b0;
        wait_drained();
        write_sched_enable(32'hFFFF_FFFF);

        // Nothing runnable, then switches with wrap, a dead task reaped,
        // keeping a running task, and a ready slot that is already current.
        send_request(req(MODE_SCHED, 0, ST_OTHER));
        send_request(req(MODE_MARK, 15, ST_OTHER));
        send_request(req(MODE_MARK, 0, ST_OTHER));
        send_request(req(MODE_SCHED, 0, ST_OTHER));
        send_request(req(MODE_SCHED, 0, ST_OTHER));
        send_request(req(MODE_WRITE, 15, ST_OTHER));
        send_request(req(MODE_WRITE, 0, ST_DEAD));
        send_request(req(MODE_WRITE, 7, ST_READY));
        send_request(req(MODE_SCHED, 0, ST_OTHER));
        send_request(req(MODE_SCHED, 0, ST_OTHER));
        send_request(req(MODE_MARK, 7, ST_OTHER));
        send_request(req(MODE_WRITE, 3, ST_READY));
        send_request(req(MODE_SETCUR, 3, ST_OTHER));
        send_request(req(MODE_SCHED, 0, ST_OTHER));
        send_request(req(MODE_WRITE, 9, ST_RUNNING));
        send_request(req(MODE_WRITE, 9, ST_OTHER));
        send_request(req(MODE_SETCUR, 15, ST_OTHER));
        send_request(req(MODE_TICK, 0, ST_OTHER));
        s_valid <= 1'b0;
        wait_drained();
        write_sched_enable(32'h0000_0000);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                en       = (phase % 4 != 2);
                cfg_word = ($urandom & 32'hFFFF_FFFE) | 32'(en);
                write_sched_enable(cfg_word);
            end
            if (phase == 1) begin
                long_hold_req = 1'b1;
            end
            if (phase == PHASES - 1) begin
                gaps_on = 1'b0;
            end
            for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
                send_request(random_request());
            end
            s_valid <= 1'b0;
            wait_drained();
        end

        if (fail_count == 0 && outstanding == 0) begin
            $display("** round_robin_task_scheduler: PASSED **");
        end else begin
            $display("** round_robin_task_scheduler: FAILED **");
        end
        $finish;
    end

endmodule
